/* hdl/easf_pkg.sv */
// Package for the encoder angle / speed filter: constants, types, shared helpers.
// No dependencies.
package easf_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned AlphaOne  = 65536;
  localparam int unsigned Deadband  = 102;

  localparam logic [2:0] REG_ANGLE_JUMP_LIMIT   = 3'd0;
  localparam logic [2:0] REG_SPIKE_REPEAT_COUNT = 3'd1;
  localparam logic [2:0] REG_ANGLE_ALPHA        = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN         = 3'd3;
  localparam logic [2:0] REG_SPEED_JUMP_LIMIT   = 3'd4;
  localparam logic [2:0] REG_SPEED_ALPHA        = 3'd5;
  localparam logic [2:0] REG_TURN_OFFSET        = 3'd6;
  localparam logic [2:0] REG_MULTI_TURN_ALPHA   = 3'd7;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_PARITY = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;
  localparam logic [1:0] STATUS_SPIKE  = 2'd3;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [30:0] angle_jump_limit;
    logic [7:0]  spike_repeat_count;
    logic [16:0] angle_alpha;
    logic [23:0] speed_gain;
    logic [30:0] speed_jump_limit;
    logic [16:0] speed_alpha;
    logic [31:0] turn_offset;
    logic [16:0] multi_turn_alpha;
  } cfg_t;

  // Shared multiplier request: every operand difference fits 36 bits signed.
  typedef struct packed {
    logic signed [35:0] a;
    logic signed [24:0] b;
  } mul_req_t;

  function automatic logic [16:0] clamp_alpha(input logic [16:0] a);
    clamp_alpha = (a > 17'(AlphaOne)) ? 17'(AlphaOne) : a;
  endfunction

endpackage

/* hdl/encoder_angle_speed_filter.sv */
// Top level of the encoder angle / speed / multi-turn filter.
// Depends on easf_pkg, easf_regs, easf_mul.
//
// Usage:
//  - Input channel: frame with in_valid / in_ready. One frame per item.
//  - Output channel: frame_status, filtered_angle, speed, multi_turn_angle with
//    out_valid / out_ready. Exactly one result item per input item.
//  - Configuration: APB-style write port; registers at byte addresses 4*i.
//    Write only while the block is idle.
//  - Sequencing: one item is in work at a time; a new frame is taken in the
//    idle state once the previous result is free or being drained, so no new
//    frame is taken before the block is through with the last one. The sequence
//    is set by four multiplies (angle IIR, speed gain, speed IIR, multi-turn IIR)
//    on the one shared registered multiplier, each followed by a state that
//    consumes its product; out_valid rises as the last state completes.
//  - Rejected frames run the same sequence; only the angle update is skipped.
//  - Reset clears all filter state and loads register defaults; out_valid low.
//  - When the receiver stalls, the result is held in the output register and
//    no new frame is accepted until that result is taken.
module encoder_angle_speed_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     frame,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      frame_status,
  output logic [31:0]                     filtered_angle,
  output logic signed [31:0]              speed,
  output logic signed [47:0]              multi_turn_angle,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [easf_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_ANG, S_ANG_W, S_GAIN, S_SPD, S_FILT, S_MT, S_MT_W
  } state_t;

  easf_pkg::cfg_t     cfg;
  easf_pkg::mul_req_t mreq;
  logic signed [60:0] prod;

  state_t             state;
  logic [1:0]         status;
  logic [31:0]        last_raw_angle;
  logic [7:0]         spike_count;
  logic [31:0]        smoothed_angle;
  logic [31:0]        speed_prev_angle;
  logic signed [31:0] last_instant_speed;
  logic signed [31:0] smoothed_speed;
  logic [31:0]        turn_prev_angle;
  logic [15:0]        turn_count;
  logic signed [47:0] smoothed_multi_turn;
  logic signed [31:0] inst;       // limited instant speed held between steps
  logic signed [35:0] mt_target;  // multi-turn target held for the last multiply

  // Frame decode.
  logic        par_bad;
  logic [31:0] raw;
  logic [31:0] raw_diff;
  logic [31:0] raw_mag;
  logic        spike;
  logic [7:0]  spike_inc;

  // Multiplier operands.
  logic [31:0]        ang_diff;
  logic [31:0]        gain_diff;
  logic signed [32:0] spd_diff;
  logic signed [48:0] mt_diff;

  // Rounded products.
  logic signed [60:0] rnd16, rnd22;

  // Speed limiting and filtering.
  logic signed [32:0] inst_sat, spd_delta, spd_mag, spd_lim, inst_lim;
  logic signed [60:0] fsum;
  logic signed [31:0] fspd;

  // Turn crossing and multi-turn target.
  logic signed [32:0] turn_dif;
  logic [15:0]        tc_next;
  logic [16:0]        ang_round;

  easf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  easf_mul u_mul (.clk, .req(mreq), .prod);

  assign par_bad   = ^frame;  // even parity over all 16 bits
  assign raw       = {frame[13:0], 18'd0};
  assign raw_diff  = raw - last_raw_angle;
  // A step of exactly half a turn has magnitude 2^31.
  assign raw_mag   = raw_diff[31] ? (32'd0 - raw_diff) : raw_diff;
  assign spike     = raw_mag > {1'b0, cfg.angle_jump_limit};
  assign spike_inc = spike_count + 8'd1;

  assign ang_diff  = last_raw_angle - smoothed_angle;  // last_raw updated at accept
  assign gain_diff = smoothed_angle - speed_prev_angle;
  assign spd_diff  = $signed({inst[31], inst}) - $signed({smoothed_speed[31], smoothed_speed});
  assign mt_diff   = $signed({{13{mt_target[35]}}, mt_target})
                   - $signed({smoothed_multi_turn[47], smoothed_multi_turn});

  // Round to nearest, ties toward plus infinity.
  assign rnd16 = (prod + 61'sd32768) >>> 16;
  assign rnd22 = (prod + 61'sd2097152) >>> 22;

  // Saturate the instant speed; a jump beyond speed_jump_limit is cut to half the step, capped at that limit.
  always_comb begin
    if (rnd22 > 61'sd2147483647)       inst_sat = 33'sd2147483647;
    else if (rnd22 < -61'sd2147483648) inst_sat = -33'sd2147483648;
    else                               inst_sat = rnd22[32:0];
    spd_delta = inst_sat - $signed({last_instant_speed[31], last_instant_speed});
    spd_mag   = spd_delta[32] ? -spd_delta : spd_delta;
    spd_lim   = spd_mag >>> 1;
    if (spd_lim > $signed({2'b0, cfg.speed_jump_limit}))
      spd_lim = $signed({2'b0, cfg.speed_jump_limit});
    if (spd_mag > $signed({2'b0, cfg.speed_jump_limit}))
      inst_lim = $signed({last_instant_speed[31], last_instant_speed})
               + (spd_delta[32] ? -spd_lim : spd_lim);
    else
      inst_lim = inst_sat;
  end

  // Filtered speed: saturate, then drop anything inside the deadband.
  always_comb begin
    fsum = $signed({{29{smoothed_speed[31]}}, smoothed_speed}) + rnd16;
    if (fsum > 61'sd2147483647)       fspd = 32'sh7FFFFFFF;
    else if (fsum < -61'sd2147483648) fspd = 32'sh80000000;
    else                              fspd = fsum[31:0];
    if (fspd >= -32'sd102 && fspd <= 32'sd102) fspd = '0;
  end

  // An exact half-turn step is not a crossing.
  assign turn_dif = $signed({1'b0, smoothed_angle}) - $signed({1'b0, turn_prev_angle});
  always_comb begin
    if (turn_dif < -33'sd2147483648)
      tc_next = turn_count + 16'd1;
    else if (turn_dif > 33'sd2147483648)
      tc_next = turn_count - 16'd1;
    else
      tc_next = turn_count;
  end
  assign ang_round = 17'(({1'b0, smoothed_angle} + 33'd32768) >> 16);

  // Multiplier operand selection, one product per step.
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      S_ANG: begin
        mreq.a = $signed({{4{ang_diff[31]}}, ang_diff});
        mreq.b = $signed({8'd0, easf_pkg::clamp_alpha(cfg.angle_alpha)});
      end
      S_GAIN: begin
        mreq.a = $signed({{4{gain_diff[31]}}, gain_diff});
        mreq.b = $signed({1'b0, cfg.speed_gain});
      end
      S_FILT: begin
        mreq.a = $signed({{3{spd_diff[32]}}, spd_diff});
        mreq.b = $signed({8'd0, easf_pkg::clamp_alpha(cfg.speed_alpha)});
      end
      S_MT: begin
        mreq.a = mt_diff[35:0];
        mreq.b = $signed({8'd0, easf_pkg::clamp_alpha(cfg.multi_turn_alpha)});
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      out_valid           <= 1'b0;
      last_raw_angle      <= '0;
      spike_count         <= '0;
      smoothed_angle      <= '0;
      speed_prev_angle    <= '0;
      last_instant_speed  <= '0;
      smoothed_speed      <= '0;
      turn_prev_angle     <= '0;
      turn_count          <= '0;
      smoothed_multi_turn <= '0;
      inst                <= '0;
      mt_target           <= '0;
      status              <= easf_pkg::STATUS_OK;
      frame_status        <= easf_pkg::STATUS_OK;
      filtered_angle      <= '0;
      speed               <= '0;
      multi_turn_angle    <= '0;
    end else begin
      // Raise the result on the last step; drop it once taken.
      if (state == S_MT_W)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            // Parity before the error flag; a held spike keeps the angle state.
            if (par_bad) begin
              status <= easf_pkg::STATUS_PARITY;
            end else if (frame[14]) begin
              status <= easf_pkg::STATUS_ERROR;
            end else if (spike && spike_inc < cfg.spike_repeat_count) begin
              spike_count <= spike_inc;
              status      <= easf_pkg::STATUS_SPIKE;
            end else begin
              spike_count    <= '0;
              last_raw_angle <= raw;
              status         <= easf_pkg::STATUS_OK;
            end
            state <= S_ANG;
          end
        end
        S_ANG: begin
          state <= S_ANG_W;
        end
        S_ANG_W: begin
          // Advance the angle only for an accepted frame.
          if (status == easf_pkg::STATUS_OK)
            smoothed_angle <= smoothed_angle + rnd16[31:0];
          state <= S_GAIN;
        end
        S_GAIN: begin
          speed_prev_angle <= smoothed_angle;
          state            <= S_SPD;
        end
        S_SPD: begin
          inst            <= inst_lim[31:0];
          turn_count      <= tc_next;
          turn_prev_angle <= smoothed_angle;
          mt_target       <= $signed({19'd0, ang_round})
                           + $signed({{4{tc_next[15]}}, tc_next, 16'd0})
                           + $signed({{4{cfg.turn_offset[31]}}, cfg.turn_offset});
          state           <= S_FILT;
        end
        S_FILT: begin
          last_instant_speed <= inst;
          state              <= S_MT;
        end
        S_MT: begin
          smoothed_speed <= fspd;
          state          <= S_MT_W;
        end
        S_MT_W: begin
          smoothed_multi_turn <= smoothed_multi_turn + rnd16[47:0];
          frame_status        <= status;
          filtered_angle      <= smoothed_angle;
          speed               <= smoothed_speed;
          multi_turn_angle    <= smoothed_multi_turn + rnd16[47:0];
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("in_ready outside the idle state");

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status) &&
      $stable(filtered_angle) && $stable(speed) && $stable(multi_turn_angle))
    else $error("result changed while stalled");

endmodule

/* hdl/easf_regs.sv */
// Configuration register file with APB-style access for the filter.
// Depends on easf_pkg.
module easf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [easf_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output easf_pkg::cfg_t                  cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_jump_limit   <= 31'd357913941;
      cfg.spike_repeat_count <= 8'd3;
      cfg.angle_alpha        <= 17'd16384;
      cfg.speed_gain         <= 24'd1200000;
      cfg.speed_jump_limit   <= 31'd1024000;
      cfg.speed_alpha        <= 17'd6554;
      cfg.turn_offset        <= 32'd0;
      cfg.multi_turn_alpha   <= 17'd65536;
    end else if (wr) begin
      case (idx)
        easf_pkg::REG_ANGLE_JUMP_LIMIT:   cfg.angle_jump_limit   <= pwdata[30:0];
        easf_pkg::REG_SPIKE_REPEAT_COUNT: cfg.spike_repeat_count <= pwdata[7:0];
        easf_pkg::REG_ANGLE_ALPHA:        cfg.angle_alpha        <= pwdata[16:0];
        easf_pkg::REG_SPEED_GAIN:         cfg.speed_gain         <= pwdata[23:0];
        easf_pkg::REG_SPEED_JUMP_LIMIT:   cfg.speed_jump_limit   <= pwdata[30:0];
        easf_pkg::REG_SPEED_ALPHA:        cfg.speed_alpha        <= pwdata[16:0];
        easf_pkg::REG_TURN_OFFSET:        cfg.turn_offset        <= pwdata;
        easf_pkg::REG_MULTI_TURN_ALPHA:   cfg.multi_turn_alpha   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      easf_pkg::REG_ANGLE_JUMP_LIMIT:   prdata = {1'b0, cfg.angle_jump_limit};
      easf_pkg::REG_SPIKE_REPEAT_COUNT: prdata = {24'd0, cfg.spike_repeat_count};
      easf_pkg::REG_ANGLE_ALPHA:        prdata = {15'd0, cfg.angle_alpha};
      easf_pkg::REG_SPEED_GAIN:         prdata = {8'd0, cfg.speed_gain};
      easf_pkg::REG_SPEED_JUMP_LIMIT:   prdata = {1'b0, cfg.speed_jump_limit};
      easf_pkg::REG_SPEED_ALPHA:        prdata = {15'd0, cfg.speed_alpha};
      easf_pkg::REG_TURN_OFFSET:        prdata = cfg.turn_offset;
      easf_pkg::REG_MULTI_TURN_ALPHA:   prdata = {15'd0, cfg.multi_turn_alpha};
      default:                          prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/easf_mul.sv */
// Shared signed multiplier with registered product, used once per sequencer step.
// Depends on easf_pkg.
module easf_mul (
  input  logic                clk,
  input  easf_pkg::mul_req_t  req,
  output logic signed [60:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= 61'(req.a) * 61'(req.b);
  end

endmodule
